/* rtl/fbsg_pkg.sv */
// Types and constants shared by the FAT boot sector geometry check.
// No dependencies.
`default_nettype none

package fbsg_pkg;

	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_BAD_SECTOR    = 4'd1,
		ST_SIZE_MISMATCH = 4'd2,
		ST_BAD_CLUSTER   = 4'd3,
		ST_ROOT_COUNT    = 4'd4,
		ST_TOTALS        = 4'd5,
		ST_FAT_ZERO      = 4'd6,
		ST_KIND_MISMATCH = 4'd7,
		ST_PARTITION     = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		KIND_FAT12 = 2'd0,
		KIND_FAT16 = 2'd1,
		KIND_FAT32 = 2'd2
	} kind_t;

	localparam logic [7:0] PTYPE_FAT12       = 8'd1;
	localparam logic [7:0] PTYPE_FAT16_SMALL = 8'd4;
	localparam logic [7:0] PTYPE_FAT16       = 8'd6;
	localparam logic [7:0] PTYPE_FAT32       = 8'd11;
	localparam logic [7:0] PTYPE_FAT32_LBA   = 8'd12;

	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;

	localparam logic [3:0] LOG2_SECTOR_MIN = 4'd9;

	typedef struct packed {
		logic [15:0] sector_size_bytes;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] root_entry_count;
		logic [15:0] total_sectors_short;
		logic [31:0] total_sectors_long;
		logic [15:0] fat_size_short;
		logic [31:0] fat_size_long;
		logic [15:0] reserved_sector_count;
		logic [7:0]  fat_copies;
		logic [7:0]  part_type_code;
		logic [3:0]  disk_log2_sector_size;
	} geom_req_t;

	typedef struct packed {
		status_t     status;
		kind_t       fs_kind;
		logic [3:0]  log2_sector_bytes;
		logic [2:0]  log2_cluster_sectors;
		logic [12:0] root_dir_sectors;
		logic [31:0] data_start_sector;
		logic [31:0] total_sectors_used;
		logic [31:0] data_cluster_count;
	} geom_res_t;

endpackage

`default_nettype wire

/* rtl/fat_boot_sector_geometry_check.sv */
// Top level of the FAT boot sector geometry check: request and result registers.
// Depends on fbsg_pkg and fbsg_eval.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  boot sector fields, partition type, disk log2 size
//   out      out_valid / out_stall status, kind, geometry, cluster count
//
// A request passes from the request register to the result register; one request per cycle unless the result stalls.
// The check runs as one pass of logic between the request and result registers.
// Reset clears both valid flags; no clearing pass is needed.
// A stalled result holds; in_stall rises only when both registers are full.
`default_nettype none

module fat_boot_sector_geometry_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] sector_size_bytes,
	input  wire logic [7:0]  sectors_per_cluster,
	input  wire logic [15:0] root_entry_count,
	input  wire logic [15:0] total_sectors_short,
	input  wire logic [31:0] total_sectors_long,
	input  wire logic [15:0] fat_size_short,
	input  wire logic [31:0] fat_size_long,
	input  wire logic [15:0] reserved_sector_count,
	input  wire logic [7:0]  fat_copies,
	input  wire logic [7:0]  part_type_code,
	input  wire logic [3:0]  disk_log2_sector_size,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       status,
	output logic [1:0]       fs_kind,
	output logic [3:0]       log2_sector_bytes,
	output logic [2:0]       log2_cluster_sectors,
	output logic [12:0]      root_dir_sectors,
	output logic [31:0]      data_start_sector,
	output logic [31:0]      total_sectors_used,
	output logic [31:0]      data_cluster_count
);
	import fbsg_pkg::*;

	logic      valid_s1;
	geom_req_t req_s1;
	logic      valid_s2;
	geom_res_t res_s2;
	geom_res_t res_comb;
	logic      adv_s2;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.sector_size_bytes     <= sector_size_bytes;
			req_s1.sectors_per_cluster   <= sectors_per_cluster;
			req_s1.root_entry_count      <= root_entry_count;
			req_s1.total_sectors_short   <= total_sectors_short;
			req_s1.total_sectors_long    <= total_sectors_long;
			req_s1.fat_size_short        <= fat_size_short;
			req_s1.fat_size_long         <= fat_size_long;
			req_s1.reserved_sector_count <= reserved_sector_count;
			req_s1.fat_copies            <= fat_copies;
			req_s1.part_type_code        <= part_type_code;
			req_s1.disk_log2_sector_size <= disk_log2_sector_size;
		end
	end

	fbsg_eval u_eval (
		.req (req_s1),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid            = valid_s2;
	assign status               = res_s2.status;
	assign fs_kind              = res_s2.fs_kind;
	assign log2_sector_bytes    = res_s2.log2_sector_bytes;
	assign log2_cluster_sectors = res_s2.log2_cluster_sectors;
	assign root_dir_sectors     = res_s2.root_dir_sectors;
	assign data_start_sector    = res_s2.data_start_sector;
	assign total_sectors_used   = res_s2.total_sectors_used;
	assign data_cluster_count   = res_s2.data_cluster_count;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("request register overwritten while result is stalled");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request lost");

	a_ok_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |->
			log2_sector_bytes >= LOG2_SECTOR_MIN && log2_sector_bytes <= 4'd12)
		else $error("ok result with sector size out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
			fs_kind == 2'd0 && root_dir_sectors == 13'd0 && data_start_sector == 32'd0 &&
			data_cluster_count == 32'd0 && total_sectors_used == 32'd0)
		else $error("error result carries nonzero fields");

endmodule

`default_nettype wire

/* rtl/fbsg_eval.sv */
// Combinational check of one boot sector request: field checks, geometry and kind.
// Depends on fbsg_pkg.
`default_nettype none

module fbsg_eval (
	input  fbsg_pkg::geom_req_t req,
	output fbsg_pkg::geom_res_t res
);
	import fbsg_pkg::*;

	logic        bps_ok;
	logic [3:0]  lbps;
	logic        spc_ok;
	logic [2:0]  lspc;
	logic        want32;
	status_t     pre_status;
	status_t     fin_status;
	logic [31:0] fat_sectors;
	logic [31:0] total;
	logic [21:0] root_num;
	logic [12:0] root;
	logic [39:0] fat_prod;
	logic [31:0] first;
	logic [31:0] diff;
	logic [31:0] clusters;
	kind_t       kind;

	always_comb begin
		bps_ok = 1'b1;
		unique case (req.sector_size_bytes)
			16'd512:  lbps = 4'd9;
			16'd1024: lbps = 4'd10;
			16'd2048: lbps = 4'd11;
			16'd4096: lbps = 4'd12;
			default: begin
				lbps   = 4'd0;
				bps_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		spc_ok = 1'b1;
		unique case (req.sectors_per_cluster)
			8'd1:   lspc = 3'd0;
			8'd2:   lspc = 3'd1;
			8'd4:   lspc = 3'd2;
			8'd8:   lspc = 3'd3;
			8'd16:  lspc = 3'd4;
			8'd32:  lspc = 3'd5;
			8'd64:  lspc = 3'd6;
			8'd128: lspc = 3'd7;
			default: begin
				lspc   = 3'd0;
				spc_ok = 1'b0;
			end
		endcase
	end

	assign want32 = (req.fat_size_short == 16'd0);

	always_comb begin
		pre_status  = ST_OK;
		fat_sectors = {16'd0, req.fat_size_short};
		total       = req.total_sectors_long;
		if (!bps_ok) begin
			pre_status = ST_BAD_SECTOR;
		end else if (req.disk_log2_sector_size != lbps) begin
			pre_status = ST_SIZE_MISMATCH;
		end else if (!spc_ok) begin
			pre_status = ST_BAD_CLUSTER;
		end else if (want32) begin
			if (req.root_entry_count != 16'd0) begin
				pre_status = ST_ROOT_COUNT;
			end else if (req.total_sectors_short != 16'd0) begin
				pre_status = ST_TOTALS;
			end else if (req.total_sectors_long == 32'd0) begin
				pre_status = ST_TOTALS;
			end else if (req.fat_size_long == 32'd0) begin
				pre_status = ST_FAT_ZERO;
			end else begin
				fat_sectors = req.fat_size_long;
			end
		end else begin
			if (req.root_entry_count == 16'd0) begin
				pre_status = ST_ROOT_COUNT;
			end else if (req.total_sectors_long == 32'd0) begin
				if (req.total_sectors_short == 16'd0) begin
					pre_status = ST_TOTALS;
				end else begin
					total = {16'd0, req.total_sectors_short};
				end
			end else if (req.total_sectors_short != 16'd0 &&
					{16'd0, req.total_sectors_short} != req.total_sectors_long) begin
				pre_status = ST_TOTALS;
			end
		end
	end

	assign root_num = {1'b0, req.root_entry_count, 5'd0}
		+ {6'd0, req.sector_size_bytes} - 22'd1;

	always_comb begin
		unique case (lbps)
			4'd9:    root = root_num[21:9];
			4'd10:   root = {1'b0, root_num[21:10]};
			4'd11:   root = {2'b0, root_num[21:11]};
			4'd12:   root = {3'b0, root_num[21:12]};
			default: root = root_num[21:9];
		endcase
	end

	assign fat_prod = {32'd0, req.fat_copies} * {8'd0, fat_sectors};
	assign first    = fat_prod[31:0] + {16'd0, req.reserved_sector_count} + {19'd0, root};
	assign diff     = total - first;
	assign clusters = diff >> lspc;

	always_comb begin
		if (clusters < FAT12_LIMIT) begin
			kind = KIND_FAT12;
		end else if (clusters < FAT16_LIMIT) begin
			kind = KIND_FAT16;
		end else begin
			kind = KIND_FAT32;
		end
	end

	always_comb begin
		fin_status = pre_status;
		if (pre_status == ST_OK) begin
			if (kind != KIND_FAT32) begin
				if (want32) begin
					fin_status = ST_KIND_MISMATCH;
				end else if (kind == KIND_FAT12 && req.part_type_code != PTYPE_FAT12) begin
					fin_status = ST_PARTITION;
				end else if (kind == KIND_FAT16 && req.part_type_code != PTYPE_FAT16_SMALL &&
						req.part_type_code != PTYPE_FAT16) begin
					fin_status = ST_PARTITION;
				end
			end else begin
				if (!want32) begin
					fin_status = ST_KIND_MISMATCH;
				end else if (req.part_type_code != PTYPE_FAT32 &&
						req.part_type_code != PTYPE_FAT32_LBA) begin
					fin_status = ST_PARTITION;
				end
			end
		end
	end

	always_comb begin
		res        = '0;
		res.status = fin_status;
		if (fin_status == ST_OK) begin
			res.fs_kind              = kind;
			res.log2_sector_bytes    = lbps;
			res.log2_cluster_sectors = lspc;
			res.root_dir_sectors     = root;
			res.data_start_sector    = first;
			res.total_sectors_used   = total;
			res.data_cluster_count   = clusters;
		end
	end

endmodule

`default_nettype wire
